### src/frpr_pkg.sv
package frpr_pkg;

  localparam int TAG_W      = 32;
  localparam int PARTS_W    = 12;
  localparam int OFF_W      = 23;
  localparam int LEN_W      = 16;
  localparam int SLOT_OUT_W = 4;
  localparam int ADDR_W     = 27;
  localparam int AGE_W      = 4;

  localparam logic [AGE_W-1:0] AGE_WINDOW_RESET = 4'd10;

  localparam int DEF_SLOTS       = 16;
  localparam int DEF_FRAME_BYTES = 8388608;
  localparam int DEF_MAX_PARTS   = 4096;

  // Depth of the header queue and of the result queue.
  localparam int QUEUE_DEPTH = 2;

  // Tag bits examined per cycle by the oldest-slot search.
  localparam int MIN_BITS = 4;

  typedef enum logic [1:0] {
    VERDICT_ACCEPT   = 2'd0,
    VERDICT_TOO_OLD  = 2'd1,
    VERDICT_OVERFLOW = 2'd2,
    VERDICT_FINISHED = 2'd3
  } verdict_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EVICT,
    ST_MIN,
    ST_PICK,
    ST_UPDATE
  } back_state_t;

  typedef struct packed {
    logic [TAG_W-1:0]   seq_id;
    logic [PARTS_W-1:0] parts;
    logic [OFF_W-1:0]   byte_offset;
    logic               overflow;
  } q_item_t;

  typedef struct packed {
    verdict_t              verdict;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic [ADDR_W-1:0]     write_address;
    logic                  frame_ready;
    logic [TAG_W-1:0]      ready_frame_id;
    logic                  stale_dropped;
  } res_t;

endpackage

### src/frpr_fifo.sv
module frpr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = frpr_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

### src/frpr_front.sv
module frpr_front #(
  parameter int FRAME_BYTES = frpr_pkg::DEF_FRAME_BYTES,
  parameter int MAX_PARTS   = frpr_pkg::DEF_MAX_PARTS
) (
  input  logic                         in_push,
  input  logic [frpr_pkg::TAG_W-1:0]   in_frame_id,
  input  logic [frpr_pkg::PARTS_W-1:0] in_parts_in_frame,
  input  logic [frpr_pkg::OFF_W-1:0]   in_byte_offset,
  input  logic [frpr_pkg::LEN_W-1:0]   in_payload_bytes,
  output logic                         q_push,
  output frpr_pkg::q_item_t            q_item
);

  localparam int FB_W  = $clog2(FRAME_BYTES + 1);
  localparam int END_W = ((frpr_pkg::OFF_W + 1) > FB_W) ? (frpr_pkg::OFF_W + 1) : FB_W;

  logic [END_W-1:0] end_w;
  logic             clamp_w;

  // The header queue drops the push on its own when full.
  assign q_push = in_push;

  always_comb begin
    end_w   = END_W'(in_byte_offset) + END_W'(in_payload_bytes);
    clamp_w = 32'(in_parts_in_frame) > 32'(MAX_PARTS - 1);
    q_item.seq_id      = in_frame_id;
    q_item.parts       = clamp_w ? frpr_pkg::PARTS_W'(MAX_PARTS - 1) : in_parts_in_frame;
    q_item.byte_offset = in_byte_offset;
    q_item.overflow    = end_w > END_W'(FRAME_BYTES);
  end

endmodule

### src/frpr_back.sv
module frpr_back #(
  parameter int SLOTS       = frpr_pkg::DEF_SLOTS,
  parameter int FRAME_BYTES = frpr_pkg::DEF_FRAME_BYTES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [frpr_pkg::AGE_W-1:0] age_window,
  input  logic                       q_empty,
  input  frpr_pkg::q_item_t          q_item,
  output logic                       q_pop,
  input  logic                       res_full,
  output logic                       res_push,
  output frpr_pkg::res_t             res_data
);

  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int TAG_W     = frpr_pkg::TAG_W;
  localparam int MIN_BITS  = frpr_pkg::MIN_BITS;
  localparam int MIN_STEPS = TAG_W / MIN_BITS;
  localparam int CNT_W     = (MIN_STEPS > 1) ? $clog2(MIN_STEPS) : 1;
  localparam int BIT_W     = $clog2(TAG_W);
  localparam int PROD_W    = SLOT_W + $clog2(FRAME_BYTES + 1) + 1;

  function automatic logic [SLOT_W-1:0] first_set(input logic [SLOTS-1:0] v);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = SLOT_W'(i);
      end
    end
    return idx;
  endfunction

  frpr_pkg::back_state_t state_r, state_nxt;

  frpr_pkg::q_item_t          item_r;
  logic [TAG_W-1:0]           newest_r;
  logic [SLOTS-1:0]           valid_r;
  logic [SLOTS-1:0]           done_r;
  logic [TAG_W-1:0]           tag_r [SLOTS];
  logic [frpr_pkg::PARTS_W-1:0] rem_mem [SLOTS];
  logic [frpr_pkg::PARTS_W-1:0] rem_rd_r;
  logic                       hit_r;
  logic                       open_r;
  logic [SLOT_W-1:0]          slot_r;
  logic [SLOTS-1:0]           cand_r;
  logic [TAG_W-1:0]           min_tag_r;
  logic [CNT_W-1:0]           min_cnt_r;

  logic [SLOTS-1:0]           hit_vec;
  logic                       hit_any;
  logic [SLOT_W-1:0]          hit_idx;
  logic                       too_old_in;
  logic                       chk_reject;
  logic [TAG_W-1:0]           newest_max;
  logic                       thr_en;
  logic [TAG_W-1:0]           thr;
  logic [SLOTS-1:0]           evict_vec;
  logic [SLOTS-1:0]           free_vec;
  logic                       free_any;
  logic [SLOT_W-1:0]          free_idx;
  logic [SLOTS-1:0]           slot_mask;
  logic [SLOTS-1:0]           older_vec;
  logic [BIT_W-1:0]           min_base;
  logic [MIN_BITS-1:0]        chunk_w [SLOTS];
  logic [SLOTS-1:0]           bit_vec;
  logic [SLOTS-1:0]           zero_vec;
  logic [SLOTS-1:0]           cand_step;
  logic [MIN_BITS-1:0]        min_chunk;
  logic                       pick_reject;
  logic [SLOT_W-1:0]          pick_idx;
  logic [frpr_pkg::PARTS_W-1:0] rem_cur;
  logic [frpr_pkg::PARTS_W-1:0] rem_dec;
  logic [PROD_W-1:0]          addr_full;

  logic                       open_en;
  logic [SLOT_W-1:0]          open_idx;
  logic [SLOTS-1:0]           open_mask;
  logic [SLOTS-1:0]           valid_clr;
  logic [SLOTS-1:0]           done_set;

  // Per-slot compares and searches.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      hit_vec[i] = valid_r[i] && (tag_r[i] == item_r.seq_id);
    end
    hit_any    = |hit_vec;
    hit_idx    = first_set(hit_vec);
    too_old_in = (newest_r >= TAG_W'(age_window)) &&
                 (item_r.seq_id < (newest_r - TAG_W'(age_window)));
    chk_reject = too_old_in || (hit_any && |(hit_vec & done_r)) || item_r.overflow;
    newest_max = (item_r.seq_id > newest_r) ? item_r.seq_id : newest_r;

    thr_en = newest_r >= TAG_W'(age_window);
    thr    = newest_r - TAG_W'(age_window);
    for (int i = 0; i < SLOTS; i++) begin
      slot_mask[i] = (slot_r == SLOT_W'(i));
      evict_vec[i] = valid_r[i] && !(hit_r && slot_mask[i]) && thr_en && (tag_r[i] < thr);
      older_vec[i] = valid_r[i] && !slot_mask[i] && (tag_r[i] < item_r.seq_id);
    end
    free_vec = ~(valid_r & ~evict_vec);
    free_any = |free_vec;
    free_idx = first_set(free_vec);

    // Oldest-slot search: a few tag bits per cycle from the top, keeping the
    // slots whose tag prefix is the smallest seen so far.
    min_base  = BIT_W'(TAG_W - 1) - BIT_W'(int'(min_cnt_r) * MIN_BITS);
    cand_step = cand_r;
    min_chunk = '0;
    bit_vec   = '0;
    zero_vec  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      chunk_w[i] = tag_r[i][min_base -: MIN_BITS];
    end
    for (int k = 0; k < MIN_BITS; k++) begin
      for (int i = 0; i < SLOTS; i++) begin
        bit_vec[i] = chunk_w[i][MIN_BITS-1-k];
      end
      zero_vec = cand_step & ~bit_vec;
      if (|zero_vec) begin
        cand_step              = zero_vec;
        min_chunk[MIN_BITS-1-k] = 1'b0;
      end else begin
        min_chunk[MIN_BITS-1-k] = 1'b1;
      end
    end
    pick_reject = min_tag_r >= item_r.seq_id;
    pick_idx    = first_set(cand_r);

    rem_cur   = open_r ? item_r.parts : rem_rd_r;
    rem_dec   = (rem_cur != '0) ? rem_cur - 1'b1 : rem_cur;
    addr_full = PROD_W'(slot_r) * PROD_W'(FRAME_BYTES) + PROD_W'(item_r.byte_offset);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      frpr_pkg::ST_IDLE: begin
        if (!q_empty && !res_full) state_nxt = frpr_pkg::ST_CHECK;
      end
      frpr_pkg::ST_CHECK: begin
        state_nxt = chk_reject ? frpr_pkg::ST_IDLE : frpr_pkg::ST_EVICT;
      end
      frpr_pkg::ST_EVICT: begin
        state_nxt = (hit_r || free_any) ? frpr_pkg::ST_UPDATE : frpr_pkg::ST_MIN;
      end
      frpr_pkg::ST_MIN: begin
        if (min_cnt_r == CNT_W'(MIN_STEPS - 1)) state_nxt = frpr_pkg::ST_PICK;
      end
      frpr_pkg::ST_PICK: begin
        state_nxt = pick_reject ? frpr_pkg::ST_IDLE : frpr_pkg::ST_UPDATE;
      end
      frpr_pkg::ST_UPDATE: begin
        state_nxt = frpr_pkg::ST_IDLE;
      end
      default: state_nxt = frpr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    res_push  = 1'b0;
    res_data  = '0;
    open_en   = 1'b0;
    open_idx  = free_idx;
    valid_clr = '0;
    done_set  = '0;
    case (state_r)
      frpr_pkg::ST_IDLE: begin
        q_pop = !q_empty && !res_full;
      end
      frpr_pkg::ST_CHECK: begin
        if (too_old_in) begin
          res_push         = 1'b1;
          res_data.verdict = frpr_pkg::VERDICT_TOO_OLD;
        end else if (hit_any && |(hit_vec & done_r)) begin
          res_push            = 1'b1;
          res_data.verdict    = frpr_pkg::VERDICT_FINISHED;
          res_data.slot_index = frpr_pkg::SLOT_OUT_W'(hit_idx);
        end else if (item_r.overflow) begin
          res_push         = 1'b1;
          res_data.verdict = frpr_pkg::VERDICT_OVERFLOW;
        end
      end
      frpr_pkg::ST_EVICT: begin
        valid_clr = evict_vec;
        open_en   = !hit_r && free_any;
      end
      frpr_pkg::ST_MIN: begin
      end
      frpr_pkg::ST_PICK: begin
        if (pick_reject) begin
          res_push         = 1'b1;
          res_data.verdict = frpr_pkg::VERDICT_TOO_OLD;
        end else begin
          open_en  = 1'b1;
          open_idx = pick_idx;
        end
      end
      frpr_pkg::ST_UPDATE: begin
        res_push               = 1'b1;
        res_data.verdict       = frpr_pkg::VERDICT_ACCEPT;
        res_data.slot_index    = frpr_pkg::SLOT_OUT_W'(slot_r);
        res_data.write_address = frpr_pkg::ADDR_W'(addr_full);
        if (rem_dec == '0) begin
          if (item_r.seq_id >= newest_r) begin
            res_data.frame_ready    = 1'b1;
            res_data.ready_frame_id = item_r.seq_id;
            done_set                = slot_mask;
            valid_clr               = older_vec;
          end else begin
            res_data.stale_dropped = 1'b1;
            valid_clr              = slot_mask;
          end
        end
      end
      default: begin
      end
    endcase
    for (int i = 0; i < SLOTS; i++) begin
      open_mask[i] = open_en && (open_idx == SLOT_W'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= frpr_pkg::ST_IDLE;
      newest_r  <= '0;
      valid_r   <= '0;
      done_r    <= '0;
      hit_r     <= 1'b0;
      open_r    <= 1'b0;
      min_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= (valid_r & ~valid_clr) | open_mask;
      done_r  <= (done_r & ~open_mask) | done_set;
      if (state_r == frpr_pkg::ST_CHECK) begin
        hit_r  <= hit_any;
        open_r <= 1'b0;
        if (!chk_reject) begin
          newest_r <= newest_max;
        end
      end
      if (open_en) begin
        open_r <= 1'b1;
      end
      if (state_r == frpr_pkg::ST_EVICT) begin
        min_cnt_r <= '0;
      end else if (state_r == frpr_pkg::ST_MIN) begin
        min_cnt_r <= min_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
    end
    if (state_r == frpr_pkg::ST_CHECK) begin
      slot_r   <= hit_idx;
      rem_rd_r <= rem_mem[hit_idx];
    end
    if (open_en) begin
      slot_r          <= open_idx;
      tag_r[open_idx] <= item_r.seq_id;
    end
    if (state_r == frpr_pkg::ST_EVICT) begin
      cand_r    <= '1;
      min_tag_r <= '0;
    end else if (state_r == frpr_pkg::ST_MIN) begin
      cand_r    <= cand_step;
      min_tag_r <= {min_tag_r[TAG_W-MIN_BITS-1:0], min_chunk};
    end
    if (state_r == frpr_pkg::ST_UPDATE) begin
      rem_mem[slot_r] <= rem_dec;
    end
  end

  // The result queue always has room for the one result of the header in work.
  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_min_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == frpr_pkg::ST_MIN) |-> (&valid_r))
    else $error("oldest-slot search started with a free slot");

  a_update_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == frpr_pkg::ST_UPDATE) |-> valid_r[slot_r])
    else $error("part counted on a slot that is not open");

  a_open_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (open_en && (state_r == frpr_pkg::ST_EVICT)) |=> valid_r[$past(open_idx)])
    else $error("opened slot not marked valid");

endmodule

### src/frame_part_reassembly_tracker_unit.sv
// Flow: the slot table sequencer takes one header at a time from the header queue. Its result
// goes to the result queue from the check state when it is rejected early, from the update
// state when it is accepted, and, when the slot table is full, from the pick or update state
// after the oldest slot is searched for (8 steps plus a pick). The sequencer takes no new
// header while the result queue is full.
// Reset (synchronous, rst_n low): slots invalid and not done, newest id zero, age window 10.
module frame_part_reassembly_tracker_unit #(
  parameter int SLOTS       = frpr_pkg::DEF_SLOTS,
  parameter int FRAME_BYTES = frpr_pkg::DEF_FRAME_BYTES,
  parameter int MAX_PARTS   = frpr_pkg::DEF_MAX_PARTS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [frpr_pkg::AGE_W-1:0]      cfg_wdata,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [frpr_pkg::TAG_W-1:0]      in_frame_id,
  input  logic [frpr_pkg::PARTS_W-1:0]    in_parts_in_frame,
  input  logic [frpr_pkg::OFF_W-1:0]      in_byte_offset,
  input  logic [frpr_pkg::LEN_W-1:0]      in_payload_bytes,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [1:0]                      out_verdict,
  output logic [frpr_pkg::SLOT_OUT_W-1:0] out_slot_index,
  output logic [frpr_pkg::ADDR_W-1:0]     out_write_address,
  output logic                            out_frame_ready,
  output logic [frpr_pkg::TAG_W-1:0]      out_ready_frame_id,
  output logic                            out_stale_dropped
);

  logic [frpr_pkg::AGE_W-1:0] age_window_r;

  logic              q_push;
  logic              q_pop;
  logic              q_empty;
  frpr_pkg::q_item_t q_din;
  frpr_pkg::q_item_t q_dout;

  logic              res_push;
  logic              res_full;
  frpr_pkg::res_t    res_din;
  frpr_pkg::res_t    res_dout;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_window_r <= frpr_pkg::AGE_WINDOW_RESET;
    end else if (cfg_we) begin
      age_window_r <= cfg_wdata;
    end
  end

  frpr_front #(
    .FRAME_BYTES (FRAME_BYTES),
    .MAX_PARTS   (MAX_PARTS)
  ) u_front (
    .in_push           (in_push),
    .in_frame_id       (in_frame_id),
    .in_parts_in_frame (in_parts_in_frame),
    .in_byte_offset    (in_byte_offset),
    .in_payload_bytes  (in_payload_bytes),
    .q_push            (q_push),
    .q_item            (q_din)
  );

  frpr_fifo #(
    .WIDTH ($bits(frpr_pkg::q_item_t)),
    .DEPTH (frpr_pkg::QUEUE_DEPTH)
  ) u_hdr_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (in_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  frpr_back #(
    .SLOTS       (SLOTS),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .age_window (age_window_r),
    .q_empty    (q_empty),
    .q_item     (q_dout),
    .q_pop      (q_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_data   (res_din)
  );

  frpr_fifo #(
    .WIDTH ($bits(frpr_pkg::res_t)),
    .DEPTH (frpr_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_din),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_dout),
    .empty (out_empty)
  );

  assign out_verdict        = res_dout.verdict;
  assign out_slot_index     = res_dout.slot_index;
  assign out_write_address  = res_dout.write_address;
  assign out_frame_ready    = res_dout.frame_ready;
  assign out_ready_frame_id = res_dout.ready_frame_id;
  assign out_stale_dropped  = res_dout.stale_dropped;

endmodule
